/* hdl/bsb_pkg.sv */
// Bit stream buffer package: word types, operation and status codes, FSM states.
// No dependencies; imported by bit_stream_buffer_unit.
`default_nettype none

package bsb_pkg;

  // Longest field moved by one write, read or peek
  localparam int unsigned MAX_BITS = 32;
  // Byte lanes of the staging buffer: an unaligned field spans one extra byte
  localparam int unsigned BUF_BYTES = (MAX_BITS + 7) / 8 + 1;
  localparam int unsigned BUF_W     = 8 * BUF_BYTES;

  // Operation codes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_PEEK  = 3'd2;
  localparam logic [2:0] OP_SEEK  = 3'd3;
  localparam logic [2:0] OP_EMPTY = 3'd4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_SHORT = 2'd2,
    STAT_ZERO  = 2'd3
  } bsb_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WFIRST,
    ST_WR,
    ST_RD,
    ST_DONE
  } bsb_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  nbits;
    logic [31:0] write_data;
    logic [15:0] seek_offset;
  } bsb_in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    bsb_status_t status;
    logic [15:0] read_position;
    logic [15:0] write_position;
    logic [15:0] occupancy;
    logic        empty_flag;
    logic        full_flag;
  } bsb_out_word_t;

endpackage

`default_nettype wire

/* hdl/bit_stream_buffer_unit.sv */
// Bit stream buffer top level: LSB-first bit stream in a byte-wide memory.
// Depends on bsb_pkg for word types, operation codes and FSM states.
//
// Usage:
//   in_valid/in_stall/in_word carry one operation word: write, read, peek,
//   seek or empty. out_valid/out_stall/out_word return one result word per
//   operation: read data, status, both bit positions, occupancy, flags.
//   cfg_wr_en/cfg_wr_data set the capacity in bytes (zero ignored, values
//   above STORE_BYTES clamp) and empty the stream; write only while idle.
// Sequencing:
//   One operation is in flight at a time. A write or read touches 1 to 5
//   store bytes through the single byte port of the store: a write reads
//   the first byte to merge its low bits, then writes one byte per cycle; a
//   read streams one byte per cycle from the registered store read. Seek,
//   empty and rejected operations touch no store bytes.
// Reset: positions go to zero, capacity to STORE_BYTES, no result pending.
//   Store contents are not cleared; only written bits are ever returned.
// Stall: a result holds in the output register while out_stall is high;
//   the next word is still accepted and worked on, and waits to finish
//   until the output register frees.
`default_nettype none

module bit_stream_buffer_unit
  import bsb_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bsb_in_word_t  in_word,
  output logic               out_valid,
  input  wire logic          out_stall,
  output bsb_out_word_t      out_word,
  input  wire logic          cfg_wr_en,
  input  wire logic [12:0]   cfg_wr_data
);

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned CAP_W  = $clog2(STORE_BYTES + 1);
  localparam int unsigned PT_W   = CAP_W + 3;
  localparam int unsigned SUM_W  = ((PT_W > 16) ? PT_W : 16) + 1;

  // Byte store
  logic [7:0] mem [STORE_BYTES];
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wd;
  logic [7:0]        mem_q_r;

  // Control state
  bsb_state_t       state_r, state_nxt;
  logic [PT_W-1:0]  rp_r, rp_nxt;
  logic [PT_W-1:0]  wp_r, wp_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r, out_valid_nxt;

  // Working registers of the item in flight
  logic [2:0]        op_r;
  logic [5:0]        cnt_r;
  logic [31:0]       wdata_r;
  logic [15:0]       offset_r;
  logic [2:0]        off_r, off_nxt;
  logic [2:0]        nbm1_r, nbm1_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [BUF_W-1:0]  acc_r, acc_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  bsb_status_t       status_r, status_nxt;
  bsb_out_word_t     out_word_r, out_word_nxt;
  logic              out_load;

  logic              in_accept;
  logic [5:0]        cnt_sat;
  logic [SUM_W-1:0]  rd_sum, wr_sum, seek_sum, cap_bits;
  logic [5:0]        span;
  logic [BUF_W-1:0]  merged;
  logic [32:0]       mask;
  logic [31:0]       rd_data;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign cnt_sat = (in_word.nbits > 6'(MAX_BITS)) ? 6'(MAX_BITS) : in_word.nbits;

  // Range checks against the current positions
  assign rd_sum   = SUM_W'(rp_r) + SUM_W'(cnt_r);
  assign wr_sum   = SUM_W'(wp_r) + SUM_W'(cnt_r);
  assign seek_sum = SUM_W'(rp_r) + SUM_W'(offset_r);
  assign cap_bits = SUM_W'({cap_r, 3'b000});

  // New bits shifted onto the low bits already in the first byte
  assign merged = (BUF_W'(wdata_r) << off_r) | BUF_W'(mem_q_r & ~(8'hFF << off_r));

  // Read field extraction
  assign mask    = (33'd1 << cnt_r) - 33'd1;
  assign rd_data = rd_ok_r ? (32'(acc_r >> off_r) & mask[31:0]) : 32'd0;

  // Memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem[mem_addr];
  end

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    off_nxt       = off_r;
    nbm1_nxt      = nbm1_r;
    k_nxt         = k_r;
    addr_nxt      = addr_r;
    acc_nxt       = acc_r;
    rd_ok_nxt     = rd_ok_r;
    status_nxt    = status_r;
    mem_addr      = addr_r;
    mem_we        = 1'b0;
    mem_wd        = acc_r[7:0];
    span          = 6'd0;
    out_load      = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_DONE;
        rd_ok_nxt  = 1'b0;
        status_nxt = STAT_OK;
        k_nxt      = 3'd0;
        case (op_r)
          OP_WRITE: begin
            if (cnt_r == 6'd0) begin
              status_nxt = STAT_ZERO;
            end else if (wr_sum > cap_bits) begin
              status_nxt = STAT_FULL;
            end else begin
              span      = 6'(wp_r[2:0]) + cnt_r - 6'd1;
              off_nxt   = wp_r[2:0];
              nbm1_nxt  = span[5:3];
              mem_addr  = ADDR_W'(wp_r >> 3);
              addr_nxt  = ADDR_W'(wp_r >> 3);
              wp_nxt    = PT_W'(wr_sum);
              state_nxt = ST_WFIRST;
            end
          end
          OP_READ, OP_PEEK: begin
            if (cnt_r == 6'd0) begin
              status_nxt = STAT_ZERO;
            end else if (rd_sum > SUM_W'(wp_r)) begin
              status_nxt = STAT_SHORT;
            end else begin
              span      = 6'(rp_r[2:0]) + cnt_r - 6'd1;
              off_nxt   = rp_r[2:0];
              nbm1_nxt  = span[5:3];
              mem_addr  = ADDR_W'(rp_r >> 3);
              addr_nxt  = ADDR_W'(rp_r >> 3) + ADDR_W'(1);
              rd_ok_nxt = 1'b1;
              if (op_r == OP_READ) begin
                rp_nxt = PT_W'(rd_sum);
              end
              state_nxt = ST_RD;
            end
          end
          OP_SEEK: begin
            rp_nxt = (seek_sum >= SUM_W'(wp_r)) ? wp_r : PT_W'(seek_sum);
          end
          OP_EMPTY: begin
            rp_nxt = '0;
            wp_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      // First byte: merge old low bits, write, keep the rest for later bytes
      ST_WFIRST: begin
        mem_we   = 1'b1;
        mem_wd   = merged[7:0];
        acc_nxt  = merged >> 8;
        addr_nxt = addr_r + ADDR_W'(1);
        k_nxt    = 3'd1;
        state_nxt = (nbm1_r == 3'd0) ? ST_DONE : ST_WR;
      end
      ST_WR: begin
        mem_we   = 1'b1;
        mem_wd   = acc_r[7:0];
        acc_nxt  = acc_r >> 8;
        addr_nxt = addr_r + ADDR_W'(1);
        k_nxt    = k_r + 3'd1;
        if (k_r == nbm1_r) begin
          state_nxt = ST_DONE;
        end
      end
      // Collect one byte per cycle while the next read is issued
      ST_RD: begin
        acc_nxt[{k_r, 3'b000} +: 8] = mem_q_r;
        addr_nxt = addr_r + ADDR_W'(1);
        k_nxt    = k_r + 3'd1;
        if (k_r == nbm1_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load                    = 1'b1;
          out_word_nxt.read_data      = rd_data;
          out_word_nxt.status         = status_r;
          out_word_nxt.read_position  = 16'(rp_r);
          out_word_nxt.write_position = 16'(wp_r);
          out_word_nxt.occupancy      = 16'(wp_r - rp_r);
          out_word_nxt.empty_flag     = (rp_r == wp_r);
          out_word_nxt.full_flag      = (SUM_W'(wp_r) == cap_bits);
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers; a capacity write empties the stream
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      cap_r       <= CAP_W'(STORE_BYTES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en && (cfg_wr_data != 13'd0)) begin
        if (32'(cfg_wr_data) > STORE_BYTES) begin
          cap_r <= CAP_W'(STORE_BYTES);
        end else begin
          cap_r <= CAP_W'(cfg_wr_data);
        end
        rp_r <= '0;
        wp_r <= '0;
      end else begin
        rp_r <= rp_nxt;
        wp_r <= wp_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_word.op;
      cnt_r    <= cnt_sat;
      wdata_r  <= in_word.write_data;
      offset_r <= in_word.seek_offset;
    end
    off_r      <= off_nxt;
    nbm1_r     <= nbm1_nxt;
    k_r        <= k_nxt;
    addr_r     <= addr_nxt;
    acc_r      <= acc_nxt;
    rd_ok_r    <= rd_ok_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire
